// ===== hw/rtl/ccd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the counter/checksum detector: request and result structs,
// configuration index and back-end state enums and byte helper constants. No dependencies.
package ccd_pkg;

    typedef struct packed {
        logic [28:0] can_id;
        logic [3:0]  byte_count;
        logic [63:0] payload;
    } req_t;

    typedef struct packed {
        logic [7:0]  counter_mask;
        logic [7:0]  checksum_mask;
        logic [7:0]  sum_kind_mask;
        logic [15:0] frames_seen;
        logic        length_matched;
        logic        table_full_drop;
    } res_t;

    typedef enum logic [0:0] {
        CFG_THRESHOLD   = 1'b0,
        CFG_MIN_SAMPLES = 1'b1
    } cfg_idx_t;

    localparam logic [7:0] ByteMask   = 8'hFF;
    localparam logic [3:0] NibbleMask = 4'hF;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_WRITE
    } bk_state_t;

endpackage

// ===== hw/rtl/ccd_front.sv =====
`timescale 1ns / 1ps
// Front end of the counter/checksum detector: identifier lookup over the tag
// table and per-byte checksum classification. Depends on ccd_pkg.
module ccd_front #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned MAX_BYTES     = 8,
    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ccd_pkg::req_t        req,
    input  logic                 tag_wr,
    input  logic [IW-1:0]        tag_wr_idx,
    output logic                 cmd_valid,
    output logic [IW-1:0]        cmd_idx,
    output logic                 cmd_found,
    output logic                 cmd_full,
    output logic                 cmd_zero,
    output logic [3:0]           cmd_len,
    output logic [63:0]          cmd_data,
    output logic [MAX_BYTES-1:0] cmd_xor_hit,
    output logic [MAX_BYTES-1:0] cmd_sum_hit
);

    logic [28:0]              tag_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [28:0]              pend_tag_reg;

    logic                     hit;
    logic [IW-1:0]            hit_idx;
    logic                     free_any;
    logic [IW-1:0]            free_idx;
    logic [3:0]               len_c;
    logic [MAX_BYTES-1:0]     xh;
    logic [MAX_BYTES-1:0]     sh;

    // Tag write comes from the back end on allocation.
    always_ff @(posedge clk)
    begin
        if (tag_wr)
        begin
            tag_mem[tag_wr_idx] <= pend_tag_reg;
        end
        if (start)
        begin
            pend_tag_reg <= req.can_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (tag_wr)
        begin
            valid_reg[tag_wr_idx] <= 1'b1;
        end
    end

    // The entry allocated by the previous request is written at the same edge
    // that takes the next one, so the lookup sees it through the pending tag.
    always_comb
    begin
        logic        pend;
        logic        ent_v;
        logic [28:0] ent_tag;
        hit      = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        pend     = 1'b0;
        ent_v    = 1'b0;
        ent_tag  = '0;
        for (int e = TABLE_ENTRIES - 1; e >= 0; e--)
        begin
            pend    = tag_wr && (tag_wr_idx == IW'(e));
            ent_v   = valid_reg[e] || pend;
            ent_tag = pend ? pend_tag_reg : tag_mem[e];
            if (ent_v && ent_tag == req.can_id)
            begin
                hit     = 1'b1;
                hit_idx = IW'(e);
            end
            if (!ent_v)
            begin
                free_any = 1'b1;
                free_idx = IW'(e);
            end
        end
    end

    always_comb
    begin
        logic [7:0] x;
        logic [7:0] s;
        logic [7:0] ob;
        len_c = (req.byte_count > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : req.byte_count;
        for (int b = 0; b < MAX_BYTES; b++)
        begin
            x  = '0;
            s  = '0;
            ob = req.payload[8*b +: 8];
            for (int p = 0; p < MAX_BYTES; p++)
            begin
                if (p != b && 4'(p) < len_c)
                begin
                    x = x ^ req.payload[8*p +: 8];
                    s = s + req.payload[8*p +: 8];
                end
            end
            xh[b] = (4'(b) < len_c) && (ob == x || ob == (~x & ccd_pkg::ByteMask));
            sh[b] = (4'(b) < len_c) && (ob == s || ob == 8'(8'd0 - s)
                    || ob == 8'(ccd_pkg::ByteMask - s));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            cmd_valid <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_idx     <= hit ? hit_idx : free_idx;
            cmd_found   <= hit;
            cmd_full    <= !hit && !free_any;
            cmd_zero    <= (req.byte_count == 4'd0);
            cmd_len     <= len_c;
            cmd_data    <= req.payload;
            cmd_xor_hit <= xh;
            cmd_sum_hit <= sh;
        end
    end

endmodule

// ===== hw/rtl/ccd_back.sv =====
`timescale 1ns / 1ps
// Back end of the counter/checksum detector: read-modify-write of the entry
// statistics memory and mask evaluation. Depends on ccd_pkg.
module ccd_back #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned COUNT_BITS    = 16,
    parameter int unsigned MAX_BYTES     = 8,
    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic [IW-1:0]        cmd_idx,
    input  logic                 cmd_found,
    input  logic                 cmd_full,
    input  logic                 cmd_zero,
    input  logic [3:0]           cmd_len,
    input  logic [63:0]          cmd_data,
    input  logic [MAX_BYTES-1:0] cmd_xor_hit,
    input  logic [MAX_BYTES-1:0] cmd_sum_hit,
    input  logic [6:0]           threshold_percent,
    input  logic [15:0]          min_samples,
    output logic                 tag_wr,
    output logic [IW-1:0]        tag_wr_idx,
    output logic                 done,
    output ccd_pkg::res_t        res
);

    localparam int unsigned CW = COUNT_BITS;
    localparam logic [CW-1:0] CntMax = '1;
    localparam int unsigned RW = 4 + 64 + 2*CW + 4*MAX_BYTES*CW;

    typedef struct packed {
        logic [3:0]                    rlen;
        logic [63:0]                   last;
        logic [CW-1:0]                 fc;
        logic [CW-1:0]                 mc;
        logic [MAX_BYTES-1:0][CW-1:0]  st;
        logic [MAX_BYTES-1:0][CW-1:0]  ch;
        logic [MAX_BYTES-1:0][CW-1:0]  xc;
        logic [MAX_BYTES-1:0][CW-1:0]  sc;
    } ent_t;

    logic [RW-1:0] ent_mem [TABLE_ENTRIES];
    ent_t          rd_reg;
    ent_t          nx;
    logic          act_reg;
    logic          wr_en;
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic [3:0]    len_reg;
    logic [63:0]   data_reg;
    logic [MAX_BYTES-1:0] xh_reg;
    logic [MAX_BYTES-1:0] sh_reg;
    logic          matched;

    // Stage 1 reads the entry; full and zero-length frames finish here.
    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            rd_reg    <= ent_t'(ent_mem[cmd_idx]);
            idx_reg   <= cmd_idx;
            found_reg <= cmd_found;
            len_reg   <= cmd_len;
            data_reg  <= cmd_data;
            xh_reg    <= cmd_xor_hit;
            sh_reg    <= cmd_sum_hit;
        end
        if (wr_en)
        begin
            ent_mem[idx_reg] <= RW'(nx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= cmd_valid && !cmd_full && !cmd_zero;
        end
    end

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v, input logic en);
        return (en && v != CntMax) ? v + 1'b1 : v;
    endfunction

    always_comb
    begin
        logic [7:0] pv;
        logic [7:0] cv;
        logic [7:0] pp;
        pv      = '0;
        cv      = '0;
        pp      = '0;
        nx      = rd_reg;
        matched = 1'b1;
        if (!found_reg)
        begin
            nx.rlen = len_reg;
            nx.last = data_reg;
            nx.fc   = CW'(1);
            nx.mc   = CW'(1);
            for (int b = 0; b < MAX_BYTES; b++)
            begin
                nx.st[b] = '0;
                nx.ch[b] = '0;
                nx.xc[b] = CW'(xh_reg[b]);
                nx.sc[b] = CW'(sh_reg[b]);
            end
        end
        else
        begin
            nx.fc   = sat_inc(rd_reg.fc, 1'b1);
            matched = (len_reg == rd_reg.rlen);
            if (matched)
            begin
                nx.mc   = sat_inc(rd_reg.mc, 1'b1);
                nx.last = data_reg;
                for (int b = 0; b < MAX_BYTES; b++)
                begin
                    pv = rd_reg.last[8*b +: 8];
                    cv = data_reg[8*b +: 8];
                    pp = pv + 8'd1;
                    if (4'(b) < len_reg)
                    begin
                        nx.ch[b] = sat_inc(rd_reg.ch[b], cv != pv);
                        nx.st[b] = sat_inc(rd_reg.st[b], cv == pp
                                   || (cv[3:0] & ccd_pkg::NibbleMask) == pp[3:0]);
                    end
                    nx.xc[b] = sat_inc(rd_reg.xc[b], xh_reg[b]);
                    nx.sc[b] = sat_inc(rd_reg.sc[b], sh_reg[b]);
                end
            end
        end
    end

    assign wr_en      = act_reg;
    assign tag_wr     = act_reg && !found_reg;
    assign tag_wr_idx = idx_reg;

    // Mask evaluation on the updated entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= act_reg || (cmd_valid && (cmd_full || cmd_zero));
        end
    end

    always_ff @(posedge clk)
    begin
        logic [CW+6:0] lhs;
        logic [CW+6:0] rhs;
        logic [CW-1:0] best;
        logic          pass;
        ccd_pkg::res_t r;
        r = '0;
        if (cmd_valid && (cmd_full || cmd_zero))
        begin
            r.table_full_drop = cmd_full && !cmd_zero;
            res               <= r;
        end
        else if (act_reg)
        begin
            pass             = (32'(nx.fc) >= 32'(min_samples));
            r.frames_seen    = (32'(nx.fc) > 32'hFFFF) ? 16'hFFFF : 16'(nx.fc);
            r.length_matched = matched;
            for (int b = 0; b < MAX_BYTES; b++)
            begin
                if (pass && 4'(b) < nx.rlen)
                begin
                    lhs = (CW+7)'(nx.st[b]) * (CW+7)'(100);
                    rhs = (CW+7)'(threshold_percent) * (CW+7)'(nx.ch[b]);
                    r.counter_mask[b] = (nx.ch[b] != '0) && lhs >= rhs;
                    best = (nx.xc[b] > nx.sc[b]) ? nx.xc[b] : nx.sc[b];
                    lhs  = (CW+7)'(best) * (CW+7)'(100);
                    rhs  = (CW+7)'(threshold_percent) * (CW+7)'(nx.mc);
                    if (nx.mc != '0 && lhs >= rhs)
                    begin
                        r.checksum_mask[b] = 1'b1;
                        r.sum_kind_mask[b] = nx.sc[b] > nx.xc[b];
                    end
                end
            end
            res <= r;
        end
    end

    a_tag_only_on_act: assert property (@(posedge clk) disable iff (!rst_n)
        tag_wr |-> act_reg)
        else $error("tag write without active entry update");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |=> done)
        else $error("entry update produced no result");
    a_drop_has_no_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.table_full_drop) |-> (res.frames_seen == 16'd0))
        else $error("dropped frame reported statistics");

endmodule

// ===== hw/rtl/counter_checksum_detector_unit.sv =====
`timescale 1ns / 1ps
// A request passes the front command register and the back-end entry read register
// before its result is strobed; zero-length and dropped requests skip the entry update.
// No request is taken while busy, which is high for one cycle after each accepted
// request while the entry read-modify-write completes.
// Reset (rst_n low, asynchronous) clears all entry valid bits and restores
// threshold_percent to 70 and min_samples to 6. Results cannot be stalled.
module counter_checksum_detector_unit #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned COUNT_BITS    = 16,
    parameter int unsigned MAX_BYTES     = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ccd_pkg::req_t request,
    output logic          strobe,
    output ccd_pkg::res_t result,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data
);

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [6:0]  thr_reg;
    logic [15:0] min_reg;
    logic        busy_reg;
    logic        accept;

    logic                 cmd_valid;
    logic [IW-1:0]        cmd_idx;
    logic                 cmd_found;
    logic                 cmd_full;
    logic                 cmd_zero;
    logic [3:0]           cmd_len;
    logic [63:0]          cmd_data;
    logic [MAX_BYTES-1:0] cmd_xh;
    logic [MAX_BYTES-1:0] cmd_sh;
    logic                 tag_wr;
    logic [IW-1:0]        tag_wr_idx;

    // A request is taken when start is high and the unit is not busy.
    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // The front stage holds one classified request in its command register, the
    // back stage reads it in the next cycle, so one request is in flight at most.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            thr_reg  <= 7'd70;
            min_reg  <= 16'd6;
        end
        else
        begin
            busy_reg <= accept;
            if (cfg_we)
            begin
                case (cfg_index)
                    ccd_pkg::CFG_THRESHOLD:   thr_reg <= cfg_data[6:0];
                    ccd_pkg::CFG_MIN_SAMPLES: min_reg <= cfg_data;
                    default:                  thr_reg <= thr_reg;
                endcase
            end
        end
    end

    ccd_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_BYTES     (MAX_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .req         (request),
        .tag_wr      (tag_wr),
        .tag_wr_idx  (tag_wr_idx),
        .cmd_valid   (cmd_valid),
        .cmd_idx     (cmd_idx),
        .cmd_found   (cmd_found),
        .cmd_full    (cmd_full),
        .cmd_zero    (cmd_zero),
        .cmd_len     (cmd_len),
        .cmd_data    (cmd_data),
        .cmd_xor_hit (cmd_xh),
        .cmd_sum_hit (cmd_sh)
    );

    ccd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS),
        .MAX_BYTES     (MAX_BYTES)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd_valid),
        .cmd_idx           (cmd_idx),
        .cmd_found         (cmd_found),
        .cmd_full          (cmd_full),
        .cmd_zero          (cmd_zero),
        .cmd_len           (cmd_len),
        .cmd_data          (cmd_data),
        .cmd_xor_hit       (cmd_xh),
        .cmd_sum_hit       (cmd_sh),
        .threshold_percent (thr_reg),
        .min_samples       (min_reg),
        .tag_wr            (tag_wr),
        .tag_wr_idx        (tag_wr_idx),
        .done              (strobe),
        .res               (result)
    );

endmodule

// ===== tb/counter_checksum_detector_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for counter_checksum_detector_unit: drives CAN frame
// requests and register writes, predicts every result and compares it.
// Depends on ccd_pkg and the counter_checksum_detector_unit RTL.
module counter_checksum_detector_unit_tb;

    localparam int unsigned NumEntries  = 64;
    localparam int unsigned NumBytes    = 8;
    localparam int unsigned CountMax    = 65535;
    localparam int unsigned PoolSize    = 24;
    localparam int unsigned IdleLimit   = 5000;
    localparam int unsigned SettleDelay = 6;
    localparam int unsigned BurstLength = 100;

    // Kinds of checksum byte that the frame generator can build.
    localparam int unsigned KindXor    = 0;
    localparam int unsigned KindXorInv = 1;
    localparam int unsigned KindSum    = 2;
    localparam int unsigned KindSumNeg = 3;
    localparam int unsigned KindSumInv = 4;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    ccd_pkg::req_t     request;
    logic              strobe;
    ccd_pkg::res_t     result;
    logic              cfg_we;
    ccd_pkg::cfg_idx_t cfg_index;
    logic [15:0]       cfg_data;

    counter_checksum_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .strobe    (strobe),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the detector's registers and identifier table. Only
    // entries that have been allocated are ever read, as in the block.
    logic [6:0]  thr_pct;
    logic [15:0] min_frames;
    logic [28:0] tag_mem     [NumEntries];
    bit          tag_used    [NumEntries];
    int unsigned ref_len     [NumEntries];
    logic [63:0] prev_data   [NumEntries];
    int unsigned frame_cnt   [NumEntries];
    int unsigned match_cnt   [NumEntries];
    int unsigned step_cnt    [NumEntries][NumBytes];
    int unsigned change_cnt  [NumEntries][NumBytes];
    int unsigned xor_cnt     [NumEntries][NumBytes];
    int unsigned sum_cnt     [NumEntries][NumBytes];

    // Results still owed by the block, oldest first.
    ccd_pkg::res_t owed_results[$];
    int unsigned   fail_count;
    int unsigned   idle_cycles;

    // Per-identifier profile used by the well-formed frame generator.
    logic [28:0] pool_id     [PoolSize];
    int unsigned pool_len    [PoolSize];
    int unsigned pool_ctr    [PoolSize];
    int unsigned pool_sum    [PoolSize];
    int unsigned pool_kind   [PoolSize];
    logic [7:0]  pool_value  [PoolSize];
    int unsigned max_gap;

    always #5 clk = ~clk;

    function automatic int unsigned sat_inc(int unsigned v);
        return (v < CountMax) ? v + 1 : v;
    endfunction

    // Bumps the XOR and sum hit counters of every byte of a frame.
    function automatic void tally_checksums(int unsigned e, logic [63:0] data,
                                            int unsigned len);
        logic [7:0] x;
        logic [7:0] s;
        logic [7:0] obs;
        for (int unsigned b = 0; b < len; b++)
        begin
            x = 8'h00;
            s = 8'h00;
            obs = data[8*b +: 8];
            for (int unsigned p = 0; p < len; p++)
            begin
                if (p != b)
                begin
                    x = x ^ data[8*p +: 8];
                    s = s + data[8*p +: 8];
                end
            end
            if (obs == x || obs == ~x)
                xor_cnt[e][b] = sat_inc(xor_cnt[e][b]);
            if (obs == s || obs == 8'(0 - s) || obs == 8'(8'hFF - s))
                sum_cnt[e][b] = sat_inc(sum_cnt[e][b]);
        end
    endfunction

    // Updates the shadow table with one accepted frame and returns the
    // result that the block has to report for it.
    function automatic ccd_pkg::res_t predict_frame(ccd_pkg::req_t r);
        ccd_pkg::res_t o;
        int unsigned   len;
        int            e;
        bit            matched;
        logic [7:0]    cur;
        logic [7:0]    prev;
        int unsigned   best;
        o = '0;
        len = r.byte_count;
        matched = 1'b0;
        e = -1;
        // A zero-length frame leaves everything alone and reports zeros.
        if (len == 0)
            return o;
        if (len > NumBytes)
            len = NumBytes;
        for (int i = 0; i < NumEntries; i++)
        begin
            if (e < 0 && tag_used[i] && tag_mem[i] == r.can_id)
                e = i;
        end
        if (e < 0)
        begin
            for (int i = 0; i < NumEntries; i++)
            begin
                if (e < 0 && !tag_used[i])
                    e = i;
            end
            // No free entry: the frame is dropped and only the flag is set.
            if (e < 0)
            begin
                o.table_full_drop = 1'b1;
                return o;
            end
            tag_used[e] = 1'b1;
            tag_mem[e] = r.can_id;
            ref_len[e] = len;
            prev_data[e] = r.payload;
            frame_cnt[e] = 1;
            match_cnt[e] = 1;
            for (int b = 0; b < NumBytes; b++)
            begin
                step_cnt[e][b] = 0;
                change_cnt[e][b] = 0;
                xor_cnt[e][b] = 0;
                sum_cnt[e][b] = 0;
            end
            tally_checksums(e, r.payload, len);
            matched = 1'b1;
        end
        else
        begin
            frame_cnt[e] = sat_inc(frame_cnt[e]);
            // A frame of another length only counts as seen.
            if (len == ref_len[e])
            begin
                matched = 1'b1;
                match_cnt[e] = sat_inc(match_cnt[e]);
                for (int unsigned b = 0; b < len; b++)
                begin
                    prev = prev_data[e][8*b +: 8];
                    cur = r.payload[8*b +: 8];
                    if (cur != prev)
                        change_cnt[e][b] = sat_inc(change_cnt[e][b]);
                    if (cur == 8'(prev + 8'd1) || cur[3:0] == 4'(prev[3:0] + 4'd1))
                        step_cnt[e][b] = sat_inc(step_cnt[e][b]);
                end
                tally_checksums(e, r.payload, len);
                prev_data[e] = r.payload;
            end
        end
        if (frame_cnt[e] >= min_frames)
        begin
            for (int unsigned b = 0; b < ref_len[e]; b++)
            begin
                best = (xor_cnt[e][b] > sum_cnt[e][b]) ? xor_cnt[e][b] : sum_cnt[e][b];
                if (change_cnt[e][b] > 0 &&
                    step_cnt[e][b] * 100 >= thr_pct * change_cnt[e][b])
                    o.counter_mask[b] = 1'b1;
                if (match_cnt[e] > 0 && best * 100 >= thr_pct * match_cnt[e])
                begin
                    o.checksum_mask[b] = 1'b1;
                    if (sum_cnt[e][b] > xor_cnt[e][b])
                        o.sum_kind_mask[b] = 1'b1;
                end
            end
        end
        o.frames_seen = 16'(frame_cnt[e]);
        o.length_matched = matched;
        return o;
    endfunction

    // Sends one request after a random gap. The request is accepted at the
    // first edge where start is high and busy is low; start is left high so
    // that back-to-back requests need no extra assignment.
    task automatic send_request(ccd_pkg::req_t r);
        int unsigned gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        owed_results.push_back(predict_frame(r));
    endtask

    // Lowers start and waits until every owed result has come back, then waits
    // out SettleDelay so that nothing is still moving through the pipeline.
    task automatic drain_results();
        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (SettleDelay) @(posedge clk);
    endtask

    // Writes one register while the block is idle.
    task automatic write_register(ccd_pkg::cfg_idx_t idx, logic [15:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ccd_pkg::CFG_THRESHOLD)
            thr_pct = value[6:0];
        else
            min_frames = value;
    endtask

    function automatic ccd_pkg::req_t make_frame(logic [28:0] id, logic [3:0] len,
                                                 logic [63:0] data);
        ccd_pkg::req_t r;
        r.can_id = id;
        r.byte_count = len;
        r.payload = data;
        return r;
    endfunction

    // Builds the checksum byte of the given kind over the other bytes.
    function automatic logic [63:0] seal_payload(logic [63:0] data, int unsigned len,
                                                 int unsigned pos, int unsigned kind);
        logic [7:0] x;
        logic [7:0] s;
        x = 8'h00;
        s = 8'h00;
        for (int unsigned p = 0; p < len; p++)
        begin
            if (p != pos)
            begin
                x = x ^ data[8*p +: 8];
                s = s + data[8*p +: 8];
            end
        end
        case (kind)
            KindXor:    data[8*pos +: 8] = x;
            KindXorInv: data[8*pos +: 8] = ~x;
            KindSum:    data[8*pos +: 8] = s;
            KindSumNeg: data[8*pos +: 8] = 8'(0 - s);
            default:    data[8*pos +: 8] = 8'(8'hFF - s);
        endcase
        return data;
    endfunction

    // Next frame of a pool identifier: mostly a rolling counter byte plus a
    // checksum byte over random content, sometimes a wrong length or noise.
    function automatic ccd_pkg::req_t next_pool_frame(int unsigned k);
        logic [63:0] data;
        int unsigned roll;
        data = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return make_frame(pool_id[k], 4'($urandom_range(0, 15)), data);
        if (roll < 16)
            return make_frame(pool_id[k], 4'(pool_len[k]), data);
        // One frame in six steps the low nibble without carry and the high nibble by three.
        if ($urandom_range(0, 5) == 0)
            pool_value[k] = {pool_value[k][7:4] + 4'd3, pool_value[k][3:0] + 4'd1};
        else
            pool_value[k] = pool_value[k] + 8'd1;
        data[8*pool_ctr[k] +: 8] = pool_value[k];
        if (pool_len[k] > 1)
            data = seal_payload(data, pool_len[k], pool_sum[k], pool_kind[k]);
        return make_frame(pool_id[k], 4'(pool_len[k]), data);
    endfunction

    task automatic test_reset_and_directed();
        logic [63:0] d;
        // Oversized lengths fold to eight bytes; a zero length is ignored.
        send_request(make_frame(29'h1FFFFFFF, 4'd0, 64'hFFFFFFFFFFFFFFFF));
        send_request(make_frame(29'h1FFFFFFF, 4'd15, 64'hFFFFFFFFFFFFFFFF));
        send_request(make_frame(29'h1FFFFFFF, 4'd9, 64'h0000000000000000));
        send_request(make_frame(29'h1FFFFFFF, 4'd8, 64'h0102030405060708));
        // Length mismatch against the first frame of an identifier.
        send_request(make_frame(29'h0, 4'd1, 64'h0));
        send_request(make_frame(29'h0, 4'd3, 64'hFFFFFFFFFFFFFF01));
        // A full-byte counter, then a low-nibble counter with a carry.
        for (int i = 0; i < 7; i++)
            send_request(make_frame(29'h0, 4'd1, 64'(8'hFC + i)));
        send_request(make_frame(29'h0, 4'd1, 64'h2F));
        send_request(make_frame(29'h0, 4'd1, 64'h50));
        // One frame per checksum kind, each on an identifier of its own.
        for (int unsigned k = KindXor; k <= KindSumInv; k++)
        begin
            d = seal_payload({$urandom, $urandom}, 8, 7, k);
            send_request(make_frame(29'(29'h7FF - k), 4'd8, d));
        end
        send_request(make_frame(29'h7FF, 4'd8, seal_payload(64'h0, 8, 7, KindXor)));
        send_request(make_frame(29'h0, 4'd1, 64'h51));
    endtask

    task automatic test_random_traffic(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            // Stretches of back-to-back requests alternate with idling.
            if (n % 50 == 0)
                max_gap = ($urandom_range(0, 2) == 0) ? 0 : 16;
            send_request(next_pool_frame($urandom_range(0, PoolSize - 1)));
        end
    endtask

    task automatic test_settings_sweep();
        write_register(ccd_pkg::CFG_THRESHOLD, 16'd0);
        write_register(ccd_pkg::CFG_MIN_SAMPLES, 16'd0);
        test_random_traffic(350);
        write_register(ccd_pkg::CFG_THRESHOLD, 16'd100);
        write_register(ccd_pkg::CFG_MIN_SAMPLES, 16'd1);
        test_random_traffic(350);
        // Thresholds above 100 can never be met.
        write_register(ccd_pkg::CFG_THRESHOLD, 16'd127);
        write_register(ccd_pkg::CFG_MIN_SAMPLES, 16'd65535);
        test_random_traffic(200);
        write_register(ccd_pkg::CFG_THRESHOLD, 16'hFFB2);
        write_register(ccd_pkg::CFG_MIN_SAMPLES, 16'd12);
        test_random_traffic(350);
        write_register(ccd_pkg::CFG_THRESHOLD, 16'd70);
        write_register(ccd_pkg::CFG_MIN_SAMPLES, 16'd6);
    endtask

    // Runs one identifier through a long back-to-back burst of frames.
    task automatic test_long_burst();
        write_register(ccd_pkg::CFG_MIN_SAMPLES, 16'd0);
        max_gap = 0;
        for (int unsigned n = 0; n < BurstLength; n++)
            send_request(make_frame(29'h15555555, 4'd2, 64'h0));
        write_register(ccd_pkg::CFG_MIN_SAMPLES, 16'd4);
    endtask

    // Fills every free entry with new identifiers, then keeps sending new
    // ones (which must be dropped) mixed with ones already in the table.
    task automatic test_table_full();
        max_gap = 16;
        for (int unsigned n = 0; n < NumEntries + 16; n++)
        begin
            send_request(make_frame(29'h0ABC0000 + 29'(n), 4'($urandom_range(1, 8)),
                                    {$urandom, $urandom}));
            if (n % 4 == 0)
                send_request(next_pool_frame($urandom_range(0, PoolSize - 1)));
        end
        test_random_traffic(300);
    endtask

    // Every strobed result is checked against the oldest owed result.
    always @(posedge clk)
    begin
        ccd_pkg::res_t want;
        if (rst_n && strobe)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result with nothing owed: %0h", result);
                fail_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (result.counter_mask !== want.counter_mask)
                begin
                    $error("counter_mask exp %0h act %0h", want.counter_mask,
                           result.counter_mask);
                    fail_count++;
                end
                if (result.checksum_mask !== want.checksum_mask)
                begin
                    $error("checksum_mask exp %0h act %0h", want.checksum_mask,
                           result.checksum_mask);
                    fail_count++;
                end
                if (result.sum_kind_mask !== want.sum_kind_mask)
                begin
                    $error("sum_kind_mask exp %0h act %0h", want.sum_kind_mask,
                           result.sum_kind_mask);
                    fail_count++;
                end
                if (result.frames_seen !== want.frames_seen)
                begin
                    $error("frames_seen exp %0d act %0d", want.frames_seen,
                           result.frames_seen);
                    fail_count++;
                end
                if (result.length_matched !== want.length_matched)
                begin
                    $error("length_matched exp %0b act %0b", want.length_matched,
                           result.length_matched);
                    fail_count++;
                end
                if (result.table_full_drop !== want.table_full_drop)
                begin
                    $error("table_full_drop exp %0b act %0b", want.table_full_drop,
                           result.table_full_drop);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without an accepted request or a result.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("[counter_checksum_detector_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = ccd_pkg::CFG_THRESHOLD;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        max_gap = 16;
        thr_pct = 7'd70;
        min_frames = 16'd6;
        for (int i = 0; i < NumEntries; i++)
            tag_used[i] = 1'b0;
        // Pool identifiers mix standard 11-bit and extended 29-bit values.
        for (int unsigned k = 0; k < PoolSize; k++)
        begin
            pool_id[k] = (k % 2) ? 29'($urandom) : 29'($urandom_range(0, 2047));
            pool_len[k] = $urandom_range(1, 8);
            pool_ctr[k] = $urandom_range(0, pool_len[k] - 1);
            pool_sum[k] = (pool_ctr[k] + 1) % pool_len[k];
            pool_kind[k] = $urandom_range(KindXor, KindSumInv);
            pool_value[k] = 8'($urandom);
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_and_directed();
        test_random_traffic(300);
        test_settings_sweep();
        test_long_burst();
        test_table_full();
        drain_results();

        if (fail_count == 0)
            $display("[counter_checksum_detector_unit] OK");
        else
            $display("[counter_checksum_detector_unit] ERROR");
        $finish;
    end

endmodule
